[rtl/imufd_pkg.sv]
// ----------------------------------------------------------------------------
// imufd_pkg: shared definitions for the IMU frame decoder
// Frame layout constants, result quantity codes, emitter states and the
// offset and quantity lookup functions.
// ----------------------------------------------------------------------------
package imufd_pkg;

  localparam int FRAME_BYTES  = 33;
  localparam int POS_W        = 6;
  localparam int WORDS        = 10;
  localparam int WORD_AW      = 4;
  localparam int SUM_DEPTH    = 3;
  localparam int SUM_AW       = 2;
  localparam int VALUE_W      = 48;
  localparam int SUM_WIDTH_DEF = 48;

  localparam logic [POS_W-1:0] LAST_OFF  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] OFF_CODE0 = 6'd1;
  localparam logic [POS_W-1:0] OFF_HDR1  = 6'd11;
  localparam logic [POS_W-1:0] OFF_CODE1 = 6'd12;
  localparam logic [POS_W-1:0] OFF_HDR2  = 6'd22;
  localparam logic [POS_W-1:0] OFF_CODE2 = 6'd23;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] CODE_ACC   = 8'h51;
  localparam logic [7:0] CODE_RATE  = 8'h52;
  localparam logic [7:0] CODE_ANGLE = 8'h53;

  localparam logic [3:0] QTY_ACC_X  = 4'd0;
  localparam logic [3:0] QTY_GYRO_X = 4'd3;
  localparam logic [3:0] QTY_GYRO_Z = 4'd5;
  localparam logic [3:0] QTY_ROLL   = 4'd6;
  localparam logic [3:0] QTY_PITCH  = 4'd7;
  localparam logic [3:0] QTY_YAW    = 4'd8;
  localparam logic [3:0] QTY_TEMP   = 4'd9;
  localparam logic [3:0] QTY_SUM_X  = 4'd10;
  localparam logic [3:0] QTY_SUM_Z  = 4'd12;

  localparam logic [WORD_AW-1:0] WORD_TEMP = 4'd3;
  localparam logic [WORD_AW-1:0] WORD_YAW  = 4'd9;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_LOAD,
    EM_ERROR
  } emit_state_t;

  // Where a frame byte lands in the word store.
  typedef struct packed {
    logic               hit;
    logic [WORD_AW-1:0] idx;
    logic               high;
  } byte_slot_t;

  function automatic byte_slot_t slot_of_offset(logic [POS_W-1:0] off);
    byte_slot_t s;
    s = '0;
    // Group 0 and group 2 words start on even offsets, group 1 on odd offsets.
    if (off >= 6'd2 && off <= 6'd9) begin
      s.hit  = 1'b1;
      s.idx  = WORD_AW'((off - 6'd2) >> 1);
      s.high = off[0];
    end else if (off >= 6'd13 && off <= 6'd18) begin
      s.hit  = 1'b1;
      s.idx  = WORD_AW'(6'd4 + ((off - 6'd13) >> 1));
      s.high = ~off[0];
    end else if (off >= 6'd24 && off <= 6'd29) begin
      s.hit  = 1'b1;
      s.idx  = WORD_AW'(6'd7 + ((off - 6'd24) >> 1));
      s.high = off[0];
    end
    return s;
  endfunction

  function automatic logic [WORD_AW-1:0] word_of_qty(logic [3:0] q);
    logic [WORD_AW-1:0] w;
    case (q) inside
      [4'd0:4'd2]: w = q;
      [4'd3:4'd7]: w = q + 4'd1;
      QTY_YAW:     w = WORD_YAW;
      QTY_TEMP:    w = WORD_TEMP;
      default:     w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [SUM_AW-1:0] sum_of_qty(logic [3:0] q);
    logic [SUM_AW-1:0] s;
    case (q) inside
      [4'd3:4'd5]:   s = SUM_AW'(q - QTY_GYRO_X);
      [4'd10:4'd12]: s = SUM_AW'(q - QTY_SUM_X);
      default:       s = '0;
    endcase
    return s;
  endfunction

endpackage

[rtl/imu_frame_decoder_with_yaw_unwrap.sv]
// ----------------------------------------------------------------------------
// imu_frame_decoder_with_yaw_unwrap: 33-byte IMU frame decoder
// Collects the little-endian words of a frame into a banked word memory and,
// at the frame end, sends thirteen tagged results (or one format error),
// with yaw unwrapping and running gyro sums held in a sum memory.
//
//   channel | side   | payload                                  | transfer when
//   in      | sink   | kind, data_byte, frame_start             | in_valid & !in_stall
//   out     | source | quantity, value, status, last            | out_valid & !out_stall
//
// A frame byte is taken every cycle unless it stalls as said below. Results of a
// good frame leave one at a time, each read from the word and sum memories
// and then loaded into the output register; an error frame gives one result.
// The word memory has two banks, so the next frame fills one while the last
// is read out. A clear or a frame-final byte stalls while results are going out.
// Reset is immediate: the sum entries carry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module imu_frame_decoder_with_yaw_unwrap #(
  parameter int SUM_WIDTH = imufd_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [7:0]                          data_byte,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          quantity,
  output logic signed [imufd_pkg::VALUE_W-1:0] value,
  output logic                                status,
  output logic                                last
);
  import imufd_pkg::*;

  // Input side.
  logic [POS_W-1:0] byte_pos;
  logic [POS_W-1:0] off_eff;
  logic             format_bad;
  logic             bad_next;
  logic             wbank;
  logic             in_acc;
  logic             byte_acc;
  logic             frame_end;
  byte_slot_t       slot;

  // Emitter.
  emit_state_t      em_state;
  emit_state_t      em_state_next;
  logic [3:0]       qty;
  logic             rbank;
  logic             em_busy;
  logic             slot_free;
  logic             load;
  logic             rd_en;
  logic             sum_we;
  logic [SUM_AW-1:0] sidx;

  // Memories and their read registers.
  logic [15:0]          word_mem [0:2**(WORD_AW+1)-1];
  logic [SUM_WIDTH-1:0] sum_mem [0:SUM_DEPTH-1];
  logic [SUM_DEPTH-1:0] sum_valid;
  logic [15:0]          word_rdata;
  logic [SUM_WIDTH-1:0] sum_rdata;
  logic                 sum_hit;

  // Unwrap state.
  logic [15:0] prev_yaw;
  logic [31:0] yaw_turns;
  logic [31:0] turns_next;

  // Datapath.
  logic signed [15:0]          word_s;
  logic signed [15:0]          prev_s;
  logic signed [16:0]          yaw_diff;
  logic signed [SUM_WIDTH-1:0] sum_cur;
  logic [SUM_WIDTH-1:0]        sum_new;
  logic signed [VALUE_W-1:0]   value_load;

  // --------------------------------------------------------------------------
  // Input handling
  // --------------------------------------------------------------------------
  always_comb begin
    if (frame_start || byte_pos > LAST_OFF) begin
      off_eff = '0;
    end else begin
      off_eff = byte_pos;
    end
  end

  assign em_busy   = (em_state != EM_IDLE);
  assign in_stall  = em_busy && (kind || off_eff == LAST_OFF);
  assign in_acc    = in_valid && !in_stall;
  assign byte_acc  = in_acc && !kind;
  assign frame_end = byte_acc && (off_eff == LAST_OFF);
  assign slot      = slot_of_offset(off_eff);

  always_comb begin
    bad_next = format_bad;
    if (off_eff == '0) begin
      bad_next = (data_byte != HDR_BYTE);
    end else if (off_eff == OFF_HDR1 || off_eff == OFF_HDR2) begin
      bad_next = format_bad || (data_byte != HDR_BYTE);
    end else if (off_eff == OFF_CODE0) begin
      bad_next = format_bad || (data_byte != CODE_ACC);
    end else if (off_eff == OFF_CODE1) begin
      bad_next = format_bad || (data_byte != CODE_RATE);
    end else if (off_eff == OFF_CODE2) begin
      bad_next = format_bad || (data_byte != CODE_ANGLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      format_bad <= 1'b0;
      wbank      <= 1'b0;
    end else if (byte_acc) begin
      byte_pos   <= frame_end ? '0 : off_eff + 6'd1;
      format_bad <= bad_next;
      // A good frame hands its bank to the emitter.
      if (frame_end && !bad_next) begin
        wbank <= ~wbank;
      end
    end
  end

  // Byte-lane writes into the current fill bank.
  always_ff @(posedge clk) begin
    if (byte_acc && slot.hit) begin
      if (slot.high) begin
        word_mem[{wbank, slot.idx}][15:8] <= data_byte;
      end else begin
        word_mem[{wbank, slot.idx}][7:0] <= data_byte;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Emitter
  // --------------------------------------------------------------------------
  assign slot_free = !out_valid || !out_stall;
  assign sidx      = sum_of_qty(qty);

  always_comb begin
    em_state_next = em_state;
    unique case (em_state)
      EM_IDLE: begin
        if (frame_end) begin
          em_state_next = bad_next ? EM_ERROR : EM_READ;
        end
      end
      EM_READ: em_state_next = EM_LOAD;
      EM_LOAD: begin
        if (slot_free) begin
          em_state_next = (qty == QTY_SUM_Z) ? EM_IDLE : EM_READ;
        end
      end
      EM_ERROR: begin
        if (slot_free) begin
          em_state_next = EM_IDLE;
        end
      end
      default: em_state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    rd_en  = 1'b0;
    load   = 1'b0;
    sum_we = 1'b0;
    unique case (em_state)
      EM_IDLE:  ;
      EM_READ:  rd_en = 1'b1;
      EM_LOAD: begin
        load   = slot_free;
        sum_we = slot_free && qty >= QTY_GYRO_X && qty <= QTY_GYRO_Z;
      end
      EM_ERROR: load = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_state <= EM_IDLE;
      qty      <= '0;
      rbank    <= 1'b0;
    end else begin
      em_state <= em_state_next;
      if (em_state == EM_IDLE && frame_end) begin
        qty   <= QTY_ACC_X;
        rbank <= wbank;
      end else if (em_state == EM_LOAD && load) begin
        qty <= qty + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      word_rdata <= word_mem[{rbank, word_of_qty(qty)}];
      sum_rdata  <= sum_mem[sidx];
      sum_hit    <= sum_valid[sidx];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sidx] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= '0;
    end else if (sum_we) begin
      sum_valid[sidx] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign word_s   = signed'(word_rdata);
  assign prev_s   = signed'(prev_yaw);
  assign yaw_diff = 17'(word_s) - 17'(prev_s);
  assign sum_cur  = sum_hit ? signed'(sum_rdata) : '0;
  assign sum_new  = sum_cur + SUM_WIDTH'(word_s);

  // A jump of more than half a turn means the yaw crossed the wrap point.
  always_comb begin
    if (yaw_diff < -17'sd32768) begin
      turns_next = yaw_turns + 32'd1;
    end else if (yaw_diff > 17'sd32768) begin
      turns_next = yaw_turns - 32'd1;
    end else begin
      turns_next = yaw_turns;
    end
  end

  always_comb begin
    case (qty) inside
      QTY_YAW:               value_load = signed'({turns_next, 16'h0000}) + VALUE_W'(word_s);
      [QTY_SUM_X:QTY_SUM_Z]: value_load = VALUE_W'(sum_cur);
      default:               value_load = VALUE_W'(word_s);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_yaw  <= '0;
      yaw_turns <= '0;
    end else if (in_acc && kind) begin
      prev_yaw  <= '0;
      yaw_turns <= '0;
    end else if (em_state == EM_LOAD && load && qty == QTY_YAW) begin
      prev_yaw  <= word_rdata;
      yaw_turns <= turns_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (em_state == EM_ERROR) begin
        quantity <= QTY_ACC_X;
        value    <= '0;
        status   <= 1'b1;
        last     <= 1'b1;
      end else begin
        quantity <= qty;
        value    <= value_load;
        status   <= 1'b0;
        last     <= (qty == QTY_SUM_Z);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_frame_end_idle: assert property (@(posedge clk) disable iff (rst)
    frame_end |-> em_state == EM_IDLE)
    else $error("frame end transfer while results still going out");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && kind) |-> em_state == EM_IDLE)
    else $error("yaw clear transfer while results still going out");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (em_state == EM_ERROR && load) |=> out_valid && status && last)
    else $error("error result not presented as a single final item");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (em_state == EM_LOAD && load && qty == QTY_SUM_Z) |=> out_valid && last && !status
      && em_state == EM_IDLE)
    else $error("good frame run did not end on the last gyro sum");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= LAST_OFF)
    else $error("byte position beyond the frame");

endmodule
